@@ rtl/core/lla_pkg.sv @@
`timescale 1ns / 1ps

package lla_pkg;

	// Grid size; the row index field stays six bits wide.
	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;

	localparam int ROW_IDX_W = 6;
	localparam int COL_IDX_W = 6;
	localparam int RULE_W    = 9;
	localparam int CFG_IDX_W = 1;

	localparam int STEP_W    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CMP_W     = (STEP_W > ROW_IDX_W) ? STEP_W : ROW_IDX_W;
	localparam int COL_SEL_W = $clog2(GRID_COLS);

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(GRID_ROWS - 1);

	localparam logic [RULE_W-1:0] BIRTH_RESET   = RULE_W'(8);
	localparam logic [RULE_W-1:0] SURVIVE_RESET = RULE_W'(12);

	localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = CFG_IDX_W'(1);

	typedef logic [GRID_COLS-1:0] row_t;
	typedef logic [RULE_W-1:0]    rule_t;

	typedef enum logic [1:0] {
		FUNC_WRITE   = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_ADVANCE = 2'd2
	} func_t;

endpackage

@@ rtl/core/lla_row_cell.sv @@
`timescale 1ns / 1ps

module lla_row_cell
	import lla_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic shift,
	input  row_t d,
	output row_t q
);

	row_t row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (shift) begin
			row_q <= d;
		end
	end

	assign q = row_q;

endmodule

@@ rtl/core/lla_rule_unit.sv @@
`timescale 1ns / 1ps

module lla_rule_unit
	import lla_pkg::*;
(
	input  row_t  above,
	input  row_t  here,
	input  row_t  below,
	input  rule_t birth_mask,
	input  rule_t survive_mask,
	output row_t  fresh
);

	// Zero padding on both sides makes the columns beyond the edge dead.
	logic [GRID_COLS+1:0] a_pad;
	logic [GRID_COLS+1:0] h_pad;
	logic [GRID_COLS+1:0] b_pad;

	assign a_pad = {1'b0, above, 1'b0};
	assign h_pad = {1'b0, here, 1'b0};
	assign b_pad = {1'b0, below, 1'b0};

	always_comb begin
		logic [3:0] n;
		rule_t      rule;
		fresh = '0;
		for (int c = 0; c < GRID_COLS; c++) begin
			n = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
			  + 4'(h_pad[c]) + 4'(h_pad[c+2])
			  + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
			rule = here[c] ? survive_mask : birth_mask;
			fresh[c] = rule[n];
		end
	end

endmodule

@@ rtl/core/life_like_automaton_step.sv @@
`timescale 1ns / 1ps

// Life-like automaton on a GRID_ROWS x GRID_COLS grid, cleared at reset. Every request
// (write a cell, read a cell, advance one generation) is served in one lap: from the edge
// that takes start, the rows rotate once around a ring of row cells past a single head
// position, where the cell is read or written or the new generation of the row is formed.
// The result shows on cell_value and op_done, which hold it, and done marks it for
// exactly one cycle and cannot be held off; busy falls in that cycle, so the next
// request may start there. The rule masks may be written whenever busy is low.
module life_like_automaton_step
	import lla_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           func,
	input  logic [ROW_IDX_W-1:0] row_index,
	input  logic [COL_IDX_W-1:0] col_index,
	input  logic                 write_value,
	output logic                 done,
	output logic                 cell_value,
	output logic                 op_done,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [RULE_W-1:0]    cfg_wdata
);

	logic                 busy_q;
	logic [STEP_W-1:0]    step_q;
	logic [1:0]           req_func_q;
	logic [ROW_IDX_W-1:0] req_row_q;
	logic [COL_IDX_W-1:0] req_col_q;
	logic                 req_val_q;
	row_t                 prev_q;
	rule_t                birth_q;
	rule_t                survive_q;
	logic                 done_q;
	logic                 cell_value_q;
	logic                 op_done_q;

	row_t cell_q [GRID_ROWS];
	row_t tail_d;
	row_t head;
	row_t below;
	row_t fresh;
	row_t bit_sel;
	logic accept;
	logic row_hit;
	logic col_ok;
	logic is_last;

	assign accept  = start && !busy_q;
	assign head    = cell_q[0];
	assign is_last = (step_q == STEP_LAST);
	assign below   = is_last ? '0 : cell_q[1];
	assign row_hit = (CMP_W'(step_q) == CMP_W'(req_row_q));
	assign col_ok  = ((COL_IDX_W+1)'(req_col_q) < (COL_IDX_W+1)'(GRID_COLS));
	assign bit_sel = row_t'(1) << req_col_q;

	// Ring of row cells: each cell takes its upper neighbor, the tail takes the head row
	// after processing. One full lap brings row 0 back to the head.
	for (genvar k = 0; k < GRID_ROWS; k++) begin : g_ring
		row_t d;
		if (k == GRID_ROWS - 1) begin : g_tail
			assign d = tail_d;
		end else begin : g_mid
			assign d = cell_q[k+1];
		end
		lla_row_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (busy_q),
			.d     (d),
			.q     (cell_q[k])
		);
	end

	lla_rule_unit u_rule (
		.above       (prev_q),
		.here        (head),
		.below       (below),
		.birth_mask  (birth_q),
		.survive_mask(survive_q),
		.fresh       (fresh)
	);

	always_comb begin
		tail_d = head;
		case (req_func_q)
			FUNC_WRITE: begin
				if (row_hit && col_ok) begin
					tail_d = req_val_q ? (head | bit_sel) : (head & ~bit_sel);
				end
			end
			FUNC_ADVANCE: begin
				tail_d = fresh;
			end
			default: begin
				tail_d = head;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			step_q    <= '0;
			done_q    <= 1'b0;
			prev_q    <= '0;
			birth_q   <= BIRTH_RESET;
			survive_q <= SURVIVE_RESET;
		end else begin
			done_q <= busy_q && is_last;
			if (cfg_we && !busy_q) begin
				if (cfg_addr == REG_BIRTH) begin
					birth_q <= cfg_wdata;
				end
				if (cfg_addr == REG_SURVIVE) begin
					survive_q <= cfg_wdata;
				end
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
				prev_q <= '0;
			end else if (busy_q) begin
				prev_q <= head;
				if (is_last) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_func_q   <= func;
			req_row_q    <= row_index;
			req_col_q    <= col_index;
			req_val_q    <= write_value;
			cell_value_q <= 1'b0;
		end else if (busy_q) begin
			if (req_func_q == FUNC_READ && row_hit && col_ok) begin
				cell_value_q <= head[req_col_q[COL_SEL_W-1:0]];
			end
			if (is_last) begin
				op_done_q <= (req_func_q == FUNC_WRITE) || (req_func_q == FUNC_READ)
				          || (req_func_q == FUNC_ADVANCE);
			end
		end
	end

	assign busy       = busy_q;
	assign done       = done_q;
	assign cell_value = cell_value_q;
	assign op_done    = op_done_q;

	// The final lap step must raise the result strobe in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && is_last |=> done_q && !busy_q)
		else $error("result strobe missing after last row");

	// A result never coincides with a request still in progress.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while busy");

	// An accepted request starts its lap at row zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q && step_q == '0)
		else $error("lap did not start at row zero");

	// Only a completed request can report a live cell.
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q && !op_done_q |-> !cell_value_q)
		else $error("cell value on an unknown request");

	// The lap counter stays within the ring while idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> step_q == '0)
		else $error("lap counter not parked at zero");

endmodule
